### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that holds at every clock edge out of reset
`define SLE_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define SLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/sle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sle_pkg;

  localparam int NUM_SPRITES  = 64;
  localparam int MAX_PER_LINE = 8;

  localparam int IDX_W  = $clog2(NUM_SPRITES);
  localparam int CNT_W  = $clog2(MAX_PER_LINE + 1);
  localparam int QP_W   = (MAX_PER_LINE > 1) ? $clog2(MAX_PER_LINE) : 1;
  localparam int ROW_W  = 6;
  localparam int DIFF_W = 10;

  localparam logic [DIFF_W-1:0] SPR_H_SHORT = DIFF_W'(8);
  localparam logic [DIFF_W-1:0] SPR_H_TALL  = DIFF_W'(16);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  localparam int PADDR_W = 3;
  localparam logic [PADDR_W-1:0] ADDR_SPRITE_TALL = PADDR_W'(0);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             wr;
    logic             shift;
    logic [ROW_W-1:0] wr_row;
    logic [7:0]       wr_value;
  } ring_ctl_t;

endpackage

`default_nettype wire

### design/sle_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sle_cmd_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] oam_address;
  logic [7:0] oam_value;
  logic [7:0] scanline;

  modport source (output valid, opcode, oam_address, oam_value, scanline, input ready);
  modport sink   (input valid, opcode, oam_address, oam_value, scanline, output ready);
endinterface

`default_nettype wire

### design/sle_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sle_res_if;
  logic       valid;
  logic       ready;
  logic [5:0] sprite_index;
  logic       found;
  logic       overflow;
  logic       last;

  modport source (output valid, sprite_index, found, overflow, last, input ready);
  modport sink   (input valid, sprite_index, found, overflow, last, output ready);
endinterface

`default_nettype wire

### design/sle_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module sle_cell (
  input  wire logic       clk,
  input  wire logic       load,
  input  wire logic       shift,
  input  wire logic [7:0] wr_value,
  input  wire logic [7:0] from_next,
  output logic      [7:0] y
);

  always_ff @(posedge clk) begin
    if (load) begin
      y <= wr_value;
    end else if (shift) begin
      y <= from_next;
    end
  end

endmodule

`default_nettype wire

### design/sle_ring.sv
`timescale 1ns / 1ps
`default_nettype none

module sle_ring (
  input  wire logic              clk,
  input  wire sle_pkg::ring_ctl_t ctl,
  output logic            [7:0]  head
);

  logic [7:0] y [sle_pkg::NUM_SPRITES];

  for (genvar i = 0; i < sle_pkg::NUM_SPRITES; i++) begin : g_cell
    logic load;

    // idle ring is aligned: cell i holds sprite i
    assign load = ctl.wr && (9'(ctl.wr_row) == 9'(i));

    sle_cell u_cell (
      .clk       (clk),
      .load      (load),
      .shift     (ctl.shift),
      .wr_value  (ctl.wr_value),
      .from_next (y[(i + 1) % sle_pkg::NUM_SPRITES]),
      .y         (y[i])
    );
  end

  assign head = y[0];

endmodule

`default_nettype wire

### design/sprite_line_evaluation_unit.sv
// Sprite line evaluation. The Y bytes of the sprites sit in a ring of cells,
// one byte per cell, which rotates by one cell per clock during an evaluation
// so that sprite k reaches the comparator at the head while scan_cnt is k. An
// attribute write is taken while idle. An evaluation makes one full turn of
// the ring (NUM_SPRITES cells, 64), then sends its result beats (1 to 8);
// the next command beat is taken once the last result beat is gone. The ring
// always makes a full turn, so it is back in place for writes afterwards.
// The user must write sprite_tall through the register port only while the
// block is idle; the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sprite_line_evaluation_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  sle_cmd_if.sink                          cmd,
  sle_res_if.source                        res,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sle_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);

  sle_pkg::state_t            state, state_next;
  sle_pkg::ring_ctl_t         ring_ctl;
  logic                       tall;
  logic [7:0]                 line;
  logic [7:0]                 head;
  logic [sle_pkg::IDX_W-1:0]  scan_cnt;
  logic [sle_pkg::CNT_W-1:0]  count;
  logic [sle_pkg::QP_W-1:0]   rd;
  logic                       ovf;
  logic                       stop;
  logic [5:0]                 q [sle_pkg::MAX_PER_LINE];
  logic [sle_pkg::DIFF_W-1:0] diff;
  logic [sle_pkg::DIFF_W-1:0] height;
  logic                       match;
  logic                       take;
  logic                       cmd_beat;
  logic                       res_beat;
  logic                       start;
  logic                       scan_done;
  logic                       last_out;
  logic                       cfg_wr;
  logic                       shift;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == sle_pkg::ADDR_SPRITE_TALL);
  assign prdata = (paddr == sle_pkg::ADDR_SPRITE_TALL) ? {31'b0, tall} : '0;

  assign cmd_beat  = cmd.valid && cmd.ready;
  assign res_beat  = res.valid && res.ready;
  assign start     = cmd_beat && (cmd.opcode == sle_pkg::OP_EVAL);
  assign scan_done = (scan_cnt == sle_pkg::IDX_W'(sle_pkg::NUM_SPRITES - 1));

  // 0 <= line - y - 1 < height
  assign height = tall ? sle_pkg::SPR_H_TALL : sle_pkg::SPR_H_SHORT;
  assign diff   = sle_pkg::DIFF_W'(line) - sle_pkg::DIFF_W'(head) - sle_pkg::DIFF_W'(1);
  assign match  = !diff[sle_pkg::DIFF_W-1] && (diff < height);
  assign take   = (state == sle_pkg::ST_SCAN) && match && !stop;

  assign ring_ctl.wr       = cmd_beat && (cmd.opcode == sle_pkg::OP_WRITE)
                             && (cmd.oam_address[1:0] == 2'b00);
  assign ring_ctl.wr_row   = cmd.oam_address[7:2];
  assign ring_ctl.wr_value = cmd.oam_value;
  assign ring_ctl.shift    = shift;

  sle_ring u_ring (
    .clk  (clk),
    .ctl  (ring_ctl),
    .head (head)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      sle_pkg::ST_IDLE: begin
        if (start) begin
          state_next = sle_pkg::ST_SCAN;
        end
      end
      sle_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_next = sle_pkg::ST_EMIT;
        end
      end
      sle_pkg::ST_EMIT: begin
        if (res.ready && last_out) begin
          state_next = sle_pkg::ST_IDLE;
        end
      end
      default: state_next = sle_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.ready = 1'b0;
    res.valid = 1'b0;
    shift     = 1'b0;
    unique case (state)
      sle_pkg::ST_IDLE: cmd.ready = 1'b1;
      sle_pkg::ST_SCAN: shift     = 1'b1;
      sle_pkg::ST_EMIT: res.valid = 1'b1;
      default: ;
    endcase
  end

  assign last_out         = (count == '0) || (sle_pkg::CNT_W'(rd) == count - 1'b1);
  assign res.found        = (count != '0);
  assign res.sprite_index = (count == '0) ? 6'd0 : q[rd];
  assign res.last         = last_out;
  assign res.overflow     = last_out && ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sle_pkg::ST_IDLE;
      tall     <= 1'b0;
      scan_cnt <= '0;
      count    <= '0;
      rd       <= '0;
      ovf      <= 1'b0;
      stop     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr) begin
        tall <= pwdata[0];
      end
      if (start) begin
        scan_cnt <= '0;
        count    <= '0;
        rd       <= '0;
        ovf      <= 1'b0;
        stop     <= 1'b0;
      end
      if (state == sle_pkg::ST_SCAN) begin
        scan_cnt <= scan_cnt + 1'b1;
        if (take) begin
          if (count < sle_pkg::CNT_W'(sle_pkg::MAX_PER_LINE)) begin
            count <= count + 1'b1;
          end else begin
            ovf  <= 1'b1;
            stop <= 1'b1;
          end
        end
      end
      if (res_beat) begin
        rd <= rd + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      line <= cmd.scanline;
    end
    if (take && (count < sle_pkg::CNT_W'(sle_pkg::MAX_PER_LINE))) begin
      q[count[sle_pkg::QP_W-1:0]] <= 6'(scan_cnt);
    end
  end

  `SLE_ASSERT(a_count_bound, count <= sle_pkg::CNT_W'(sle_pkg::MAX_PER_LINE), "match count too high")
  `SLE_ASSERT(a_ovf_full, !ovf || (count == sle_pkg::CNT_W'(sle_pkg::MAX_PER_LINE)), "overflow without full list")
  `SLE_ASSERT_NEXT(a_scan_turn, (state == sle_pkg::ST_SCAN) && scan_done, state == sle_pkg::ST_EMIT, "scan did not end after full turn")
  `SLE_ASSERT_NEXT(a_last_idle, res_beat && res.last, state == sle_pkg::ST_IDLE, "no return to idle after last beat")

endmodule

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [sle_pkg::IDX_W-1:0] sprite_index;
    logic                      found;
    logic                      overflow;
    logic                      last;
  } line_hit_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [sle_pkg::PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sle_cmd_if cmd_if ();
  sle_res_if res_if ();

  sprite_line_evaluation_unit dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_if),
    .res     (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow of the Y store and the height mode
  logic [7:0] y_shadow [sle_pkg::NUM_SPRITES];
  logic       tall_shadow;
  line_hit_t  pending_hits [$];

  int err_count;
  int cycle_count;
  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void store_y_byte(input logic [7:0] addr, input logic [7:0] val);
    if (addr[1:0] == 2'b00) begin
      y_shadow[addr[7:2]] = val;
    end
  endfunction

  function automatic void predict_line(input logic [7:0] line);
    int        height;
    int        count;
    int        dy;
    bit        spilled;
    line_hit_t hit;
    logic [sle_pkg::IDX_W-1:0] hits [sle_pkg::MAX_PER_LINE];
    height = tall_shadow ? 16 : 8;
    count = 0;
    spilled = 1'b0;
    for (int si = 0; si < sle_pkg::NUM_SPRITES && !spilled; si++) begin
      dy = int'(line) - int'(y_shadow[si]) - 1;
      if (dy >= 0 && dy < height) begin
        if (count < sle_pkg::MAX_PER_LINE) begin
          hits[count] = sle_pkg::IDX_W'(si);
          count++;
        end else begin
          spilled = 1'b1;
        end
      end
    end
    if (count == 0) begin
      hit = '{sprite_index: '0, found: 1'b0, overflow: 1'b0, last: 1'b1};
      pending_hits.push_back(hit);
    end
    for (int k = 0; k < count; k++) begin
      hit.sprite_index = hits[k];
      hit.found = 1'b1;
      hit.last = (k == count - 1);
      hit.overflow = hit.last && spilled;
      pending_hits.push_back(hit);
    end
  endfunction

  // result side: random ready, long hold-offs, and the check of each beat
  always @(posedge clk) begin
    line_hit_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (pending_hits.size() == 0) begin
        $error("sprite beat with nothing expected: index %0d found %0b",
               res_if.sprite_index, res_if.found);
        err_count++;
      end else begin
        want = pending_hits.pop_front();
        if (res_if.sprite_index !== want.sprite_index) begin
          $error("sprite_index: expected %0d, got %0d", want.sprite_index, res_if.sprite_index);
          err_count++;
        end
        if (res_if.found !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, res_if.found);
          err_count++;
        end
        if (res_if.overflow !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, res_if.overflow);
          err_count++;
        end
        if (res_if.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, res_if.last);
          err_count++;
        end
      end
    end
    if (rst) begin
      res_if.ready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_beat(input logic op, input logic [7:0] addr, input logic [7:0] val,
                           input logic [7:0] line);
    while ($urandom_range(99) < tx_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.opcode      <= op;
    cmd_if.oam_address <= addr;
    cmd_if.oam_value   <= val;
    cmd_if.scanline    <= line;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    if (op == sle_pkg::OP_EVAL) begin
      predict_line(line);
    end else begin
      store_y_byte(addr, val);
    end
  endtask

  task automatic send_write(input logic [7:0] addr, input logic [7:0] val);
    send_beat(sle_pkg::OP_WRITE, addr, val, 8'($urandom()));
  endtask

  task automatic send_eval(input logic [7:0] line);
    send_beat(sle_pkg::OP_EVAL, 8'($urandom()), 8'($urandom()), line);
  endtask

  // drop valid in the step of the last handshake, then wait for the block to go quiet
  task automatic wait_drain();
    cmd_if.valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_tall(input logic val);
    wait_drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= sle_pkg::ADDR_SPRITE_TALL;
    pwdata  <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tall_shadow = val;
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== 32'(tall_shadow)) begin
      $error("sprite_tall: expected %0h, got %0h", 32'(tall_shadow), prdata);
      err_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_load_store();
    for (int i = 0; i < sle_pkg::NUM_SPRITES; i++) begin
      send_write(8'(i * 4), 8'hFF);
    end
  endtask

  task automatic test_directed_cases();
    send_eval(8'd0);
    send_eval(8'd255);
    send_write(8'h00, 8'h00);
    send_eval(8'd1);
    send_eval(8'd8);
    send_eval(8'd9);
    // unaligned writes leave the store alone
    send_write(8'h01, 8'h05);
    send_write(8'hFF, 8'h05);
    send_write(8'hFE, 8'h05);
    send_eval(8'd1);
    send_write(8'hFC, 8'hF0);
    send_eval(8'd241);
    // nine sprites on one line
    for (int i = 20; i < 29; i++) begin
      send_write(8'(i * 4), 8'd100);
    end
    send_eval(8'd108);
  endtask

  task automatic test_tall_mode();
    write_tall(1'b1);
    send_eval(8'd9);
    send_eval(8'd16);
    send_eval(8'd17);
    send_eval(8'd115);
    send_eval(8'd117);
    write_tall(1'b0);
  endtask

  task automatic test_random_phase(input int tx_pct, input int rx_pct, input logic tall,
                                   input int n_items);
    int         sent;
    int         nwr;
    logic [7:0] center;
    logic [7:0] line;
    write_tall(tall);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < n_items) begin
      center = 8'($urandom());
      nwr = $urandom_range(0, 12);
      repeat (nwr) begin
        if ($urandom_range(9) == 0) begin
          send_write({6'($urandom()), 2'($urandom_range(1, 3))}, 8'($urandom()));
        end else begin
          send_write({6'($urandom()), 2'b00}, center + 8'($urandom_range(0, 10)) - 8'd5);
          sent++;
        end
      end
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(7) == 0) begin
          line = 8'($urandom());
        end else begin
          line = center + 8'($urandom_range(0, 20));
        end
        send_eval(line);
        sent++;
      end
    end
    wait_drain();
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    wait_drain();
    @(negedge clk);
    rx_hold = 400;
    @(posedge clk);
    for (int i = 0; i < 8; i++) begin
      send_eval(8'($urandom()));
    end
    wait_drain();
  endtask

  initial begin
    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    cmd_if.valid       = 1'b0;
    cmd_if.opcode      = sle_pkg::OP_WRITE;
    cmd_if.oam_address = '0;
    cmd_if.oam_value   = '0;
    cmd_if.scanline    = '0;
    res_if.ready       = 1'b0;
    tall_shadow        = 1'b0;
    err_count          = 0;
    cycle_count        = 0;
    tx_idle_pct        = 18;
    rx_idle_pct        = 74;
    rx_hold            = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_load_store();
    test_directed_cases();
    test_tall_mode();
    test_random_phase(18, 74, 1'b1, 60);
    test_random_phase(74, 18, 1'b0, 60);
    test_random_phase(0, 0, 1'b1, 60);
    test_backpressure();

    wait_drain();
    repeat (80) @(posedge clk);
    if (err_count == 0 && pending_hits.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
